/* hdl/spc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package spc_pkg;

    // path command codes
    localparam logic [3:0] REQ_MOVE     = 4'd0;
    localparam logic [3:0] REQ_LINE     = 4'd1;
    localparam logic [3:0] REQ_HLINE    = 4'd2;
    localparam logic [3:0] REQ_VLINE    = 4'd3;
    localparam logic [3:0] REQ_CUBIC    = 4'd4;
    localparam logic [3:0] REQ_SCUBIC   = 4'd5;
    localparam logic [3:0] REQ_QUAD     = 4'd6;
    localparam logic [3:0] REQ_SQUAD    = 4'd7;
    localparam logic [3:0] REQ_CLOSE    = 4'd8;

    // segment kinds
    localparam logic [1:0] KIND_MOVE    = 2'd0;
    localparam logic [1:0] KIND_LINE    = 2'd1;
    localparam logic [1:0] KIND_CUBIC   = 2'd2;
    localparam logic [1:0] KIND_CLOSE   = 2'd3;

    // configuration register indexes
    localparam logic [0:0] CFG_NUDGE_EN  = 1'd0;
    localparam logic [0:0] CFG_NUDGE_AMT = 1'd1;

    // floor(u / 3) for a 34-bit u split at bit SPLIT_BITS:
    // u = a * 2^17 + b  ->  u / 3 = a * (2^17 / 3) + (2a + b) / 3
    localparam int SPLIT_BITS  = 17;
    localparam int QUOT_HI     = (2 ** SPLIT_BITS) / 3;
    // (2a + b) fits 19 bits; reciprocal of 3 with a 20-bit shift is exact there
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP3      = (2 ** RECIP_SHIFT) / 3 + 1;
    // bias that lifts 2d + 1 to a positive multiple-of-three offset
    localparam logic [33:0] DIV_BIAS = 34'h3_0000_0000;

    // one command's work as it moves down the pipeline
    typedef struct packed {
        logic        need_move;
        logic [1:0]  kind;
        logic        is_quad;
        logic [31:0] mv_x;
        logic [31:0] mv_y;
        logic [31:0] p0_x;
        logic [31:0] p0_y;
        logic [31:0] p1_x;
        logic [31:0] p1_y;
        logic [31:0] d_x;
        logic [31:0] d_y;
    } item_t;

    // stage load enables shared by the two-thirds lanes
    typedef struct packed {
        logic ld2;
        logic ld3;
        logic ld4;
        logic ld5;
    } adv_t;

endpackage

`default_nettype wire

/* hdl/spc_third.sv */
`timescale 1ns / 1ps
`default_nettype none

// from + round(2 * (toward - from) / 3), four registered steps
module spc_third (
    input  wire logic         aclk,
    input  wire spc_pkg::adv_t adv,
    input  wire logic [31:0]  from_i,
    input  wire logic [31:0]  toward_i,
    output logic      [31:0]  c_o
);

    logic [31:0] from2_reg, from3_reg, from4_reg;
    logic [33:0] u2_reg;
    logic [18:0] v3_reg;
    logic [32:0] pa3_reg, pa4_reg;
    logic [37:0] pv4_reg;
    logic [31:0] c5_reg;

    logic [31:0] diff;
    logic [16:0] u_hi;
    logic [16:0] u_lo;

    assign diff = toward_i - from_i;
    assign u_hi = u2_reg[33:spc_pkg::SPLIT_BITS];
    assign u_lo = u2_reg[spc_pkg::SPLIT_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (adv.ld2) begin
            // 2d + 1 sign extended, lifted positive
            u2_reg    <= {diff[31], diff, 1'b1} + spc_pkg::DIV_BIAS;
            from2_reg <= from_i;
        end
        if (adv.ld3) begin
            v3_reg    <= {1'b0, u_hi, 1'b0} + {2'b00, u_lo};
            pa3_reg   <= {16'd0, u_hi} * 33'(spc_pkg::QUOT_HI);
            from3_reg <= from2_reg;
        end
        if (adv.ld4) begin
            pv4_reg   <= {19'd0, v3_reg} * 38'(spc_pkg::RECIP3);
            pa4_reg   <= pa3_reg;
            from4_reg <= from3_reg;
        end
        if (adv.ld5) begin
            // bias term drops out modulo 2^32
            c5_reg <= from4_reg + pa4_reg[31:0]
                      + {14'd0, pv4_reg[37:spc_pkg::RECIP_SHIFT]};
        end
    end

    assign c_o = c5_reg;

endmodule

`default_nettype wire

/* hdl/svg_path_to_cubic_segments_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  beat contents
// s_axis    in   one path command: tuser type and relative flag, tdata three points
// m_axis    out  one segment: tuser kind, tdata two controls and target,
//                tlast on a command's final one
// cfg       in   register write, index 0 nudge enable, index 1 nudge amount
//
// one command is accepted per cycle while s_tready is high; a non-moveto command
// that opens a subpath gives two beats (leading moveto), holding stage 5 for both
// each beat passes st1_reg to st5_reg and the output register on its way to m_axis;
// the divide-by-three lanes step through difference, split, multiply and sum
// a stage loads when empty or when its beat moves on, so bubbles close up while
// m_tready is low; the ready chain is combinational, up to six commands are held
// aresetn clears the path state, pipeline valids and config to defaults
module svg_path_to_cubic_segments_top (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // command stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // ctrl1_x[31:0], ctrl1_y[63:32], ctrl2_x[95:64], ctrl2_y[127:96],
    // end_x[159:128], end_y[191:160]
    input  wire logic [191:0] s_tdata,
    // req_type[3:0], relative[4]
    input  wire logic [4:0]   s_tuser,
    // segment stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // pt0_x[31:0], pt0_y[63:32], pt1_x[95:64], pt1_y[127:96],
    // dest_x[159:128], dest_y[191:160]
    output logic      [191:0] m_tdata,
    // seg_kind[1:0]
    output logic      [1:0]   m_tuser,
    output logic              m_tlast,
    // configuration writes
    input  wire logic         cfg_we,
    input  wire logic [0:0]   cfg_index,
    input  wire logic [15:0]  cfg_wdata
);

    // ---------------------------------------------------------------
    // configuration
    // ---------------------------------------------------------------
    logic        nudge_en_reg;
    logic [15:0] nudge_amt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nudge_en_reg  <= 1'b1;
            nudge_amt_reg <= 16'd655;
        end else if (cfg_we) begin
            unique case (cfg_index)
                spc_pkg::CFG_NUDGE_EN:  nudge_en_reg  <= cfg_wdata[0];
                spc_pkg::CFG_NUDGE_AMT: nudge_amt_reg <= cfg_wdata;
                default:                nudge_en_reg  <= nudge_en_reg;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // command fields
    // ---------------------------------------------------------------
    logic [3:0]  req;
    logic        rel;
    logic [31:0] c1x, c1y, c2x, c2y, ex, ey;

    assign req = s_tuser[3:0];
    assign rel = s_tuser[4];
    assign c1x = s_tdata[31:0];
    assign c1y = s_tdata[63:32];
    assign c2x = s_tdata[95:64];
    assign c2y = s_tdata[127:96];
    assign ex  = s_tdata[159:128];
    assign ey  = s_tdata[191:160];

    // ---------------------------------------------------------------
    // path state
    // ---------------------------------------------------------------
    logic [31:0] cur_x_reg, cur_y_reg, sub_x_reg, sub_y_reg, prev_x_reg, prev_y_reg;
    logic        was_cubic_reg, was_quad_reg, new_sub_reg;
    logic [31:0] cur_x_next, cur_y_next, sub_x_next, sub_y_next, prev_x_next, prev_y_next;
    logic        was_cubic_next, was_quad_next, new_sub_next;

    // pipeline control, stage k holds st_reg[k]
    logic [5:1]     vld_reg;
    logic           pend_reg;       // leading moveto of stage 5 still to go
    logic [5:1]     rdy;
    logic [5:1]     go;
    spc_pkg::item_t st1_next;
    spc_pkg::item_t st1_reg, st2_reg, st3_reg, st4_reg, st5_reg;
    spc_pkg::adv_t  adv;

    logic        s_fire;
    logic        req_ok;
    logic [31:0] ox, oy;
    logic [31:0] c1xa, c1ya, c2xa, c2ya, exa, eya;
    logic [31:0] refl_x, refl_y;
    logic [31:0] cq_x, cq_y, qq_x, qq_y;

    assign s_fire = s_tvalid && s_tready;
    assign req_ok = (req <= spc_pkg::REQ_CLOSE);

    assign ox   = rel ? cur_x_reg : 32'd0;
    assign oy   = rel ? cur_y_reg : 32'd0;
    assign c1xa = c1x + ox;
    assign c1ya = c1y + oy;
    assign c2xa = c2x + ox;
    assign c2ya = c2y + oy;
    assign exa  = ex + ox;
    assign eya  = ey + oy;

    // reflection of the previous control about the current point
    assign refl_x = {cur_x_reg[30:0], 1'b0} - prev_x_reg;
    assign refl_y = {cur_y_reg[30:0], 1'b0} - prev_y_reg;

    // first control of a cubic, sole control of a quadratic
    always_comb begin
        if (req == spc_pkg::REQ_CUBIC) begin
            cq_x = c1xa;
            cq_y = c1ya;
        end else if (was_cubic_reg) begin
            cq_x = refl_x;
            cq_y = refl_y;
        end else begin
            cq_x = cur_x_reg;
            cq_y = cur_y_reg;
        end
        if (req == spc_pkg::REQ_QUAD) begin
            qq_x = c2xa;
            qq_y = c2ya;
        end else if (was_quad_reg) begin
            qq_x = refl_x;
            qq_y = refl_y;
        end else begin
            qq_x = cur_x_reg;
            qq_y = cur_y_reg;
        end
    end

    always_comb begin
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        sub_x_next     = sub_x_reg;
        sub_y_next     = sub_y_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        was_cubic_next = 1'b0;
        was_quad_next  = 1'b0;
        new_sub_next   = 1'b0;

        st1_next           = '0;
        st1_next.need_move = new_sub_reg && (req != spc_pkg::REQ_MOVE);
        st1_next.mv_x      = sub_x_reg;
        st1_next.mv_y      = sub_y_reg;

        unique case (req)
            spc_pkg::REQ_MOVE: begin
                cur_x_next    = exa;
                cur_y_next    = eya;
                sub_x_next    = exa;
                sub_y_next    = eya;
                st1_next.kind = spc_pkg::KIND_MOVE;
                st1_next.d_x  = exa;
                st1_next.d_y  = eya;
            end
            spc_pkg::REQ_LINE, spc_pkg::REQ_HLINE, spc_pkg::REQ_VLINE: begin
                if (req != spc_pkg::REQ_VLINE) begin
                    cur_x_next = exa;
                end
                if (req != spc_pkg::REQ_HLINE) begin
                    cur_y_next = eya;
                end
                st1_next.kind = spc_pkg::KIND_LINE;
                st1_next.d_x  = (req != spc_pkg::REQ_VLINE) ? exa : cur_x_reg;
                st1_next.d_y  = (req != spc_pkg::REQ_HLINE) ? eya : cur_y_reg;
            end
            spc_pkg::REQ_CUBIC, spc_pkg::REQ_SCUBIC: begin
                cur_x_next     = exa;
                cur_y_next     = eya;
                prev_x_next    = c2xa;
                prev_y_next    = c2ya;
                was_cubic_next = 1'b1;
                st1_next.kind  = spc_pkg::KIND_CUBIC;
                st1_next.p0_x  = cq_x;
                st1_next.p0_y  = cq_y;
                st1_next.p1_x  = c2xa;
                st1_next.p1_y  = c2ya;
                st1_next.d_x   = exa;
                st1_next.d_y   = eya;
            end
            spc_pkg::REQ_QUAD, spc_pkg::REQ_SQUAD: begin
                cur_x_next       = exa;
                cur_y_next       = eya;
                prev_x_next      = qq_x;
                prev_y_next      = qq_y;
                was_quad_next    = 1'b1;
                st1_next.kind    = spc_pkg::KIND_CUBIC;
                st1_next.is_quad = 1'b1;
                // lanes take p0 -> p1 and d -> p1
                st1_next.p0_x    = cur_x_reg;
                st1_next.p0_y    = cur_y_reg;
                st1_next.p1_x    = qq_x;
                st1_next.p1_y    = qq_y;
                st1_next.d_x     = exa;
                st1_next.d_y     = eya;
            end
            spc_pkg::REQ_CLOSE: begin
                cur_x_next    = sub_x_reg;
                cur_y_next    = sub_y_reg;
                new_sub_next  = 1'b1;
                st1_next.kind = spc_pkg::KIND_CLOSE;
                st1_next.d_x  = sub_x_reg;
                st1_next.d_y  = sub_y_reg;
            end
            default: begin
                // unknown code: dropped, state kept
                was_cubic_next = was_cubic_reg;
                was_quad_next  = was_quad_reg;
                new_sub_next   = new_sub_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            sub_x_reg     <= '0;
            sub_y_reg     <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            was_cubic_reg <= 1'b0;
            was_quad_reg  <= 1'b0;
            new_sub_reg   <= 1'b1;
        end else if (s_fire) begin
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            sub_x_reg     <= sub_x_next;
            sub_y_reg     <= sub_y_next;
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            was_cubic_reg <= was_cubic_next;
            was_quad_reg  <= was_quad_next;
            new_sub_reg   <= new_sub_next;
        end
    end

    // ---------------------------------------------------------------
    // pipeline handshake: a stage loads when empty or emptying
    // ---------------------------------------------------------------
    logic out_vld_reg;
    logic out_ld;

    assign out_ld = vld_reg[5] && (!out_vld_reg || m_tready);
    assign go[5]  = out_ld && !pend_reg;
    assign rdy[5] = !vld_reg[5] || go[5];
    assign go[4]  = vld_reg[4] && rdy[5];
    assign rdy[4] = !vld_reg[4] || go[4];
    assign go[3]  = vld_reg[3] && rdy[4];
    assign rdy[3] = !vld_reg[3] || go[3];
    assign go[2]  = vld_reg[2] && rdy[3];
    assign rdy[2] = !vld_reg[2] || go[2];
    assign go[1]  = vld_reg[1] && rdy[2];
    assign rdy[1] = !vld_reg[1] || go[1];

    assign s_tready = rdy[1];

    assign adv.ld2 = rdy[2];
    assign adv.ld3 = rdy[3];
    assign adv.ld4 = rdy[4];
    assign adv.ld5 = rdy[5];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            pend_reg <= 1'b0;
        end else begin
            if (rdy[1]) begin
                vld_reg[1] <= s_fire && req_ok;
            end
            if (rdy[2]) begin
                vld_reg[2] <= vld_reg[1];
            end
            if (rdy[3]) begin
                vld_reg[3] <= vld_reg[2];
            end
            if (rdy[4]) begin
                vld_reg[4] <= vld_reg[3];
            end
            if (rdy[5]) begin
                vld_reg[5] <= vld_reg[4];
                pend_reg   <= vld_reg[4] && st4_reg.need_move;
            end else if (out_ld) begin
                // moveto beat went out, main segment next
                pend_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            st1_reg <= st1_next;
        end
        if (rdy[2]) begin
            st2_reg <= st1_reg;
        end
        if (rdy[3]) begin
            st3_reg <= st2_reg;
        end
        if (rdy[4]) begin
            st4_reg <= st3_reg;
        end
        if (rdy[5]) begin
            st5_reg <= st4_reg;
        end
    end

    // ---------------------------------------------------------------
    // quadratic to cubic: four two-thirds lanes
    // ---------------------------------------------------------------
    logic [31:0] tq0_x, tq0_y, tq1_x, tq1_y;

    spc_third u_third_p0x (
        .aclk     (aclk),
        .adv      (adv),
        .from_i   (st1_reg.p0_x),
        .toward_i (st1_reg.p1_x),
        .c_o      (tq0_x)
    );

    spc_third u_third_p0y (
        .aclk     (aclk),
        .adv      (adv),
        .from_i   (st1_reg.p0_y),
        .toward_i (st1_reg.p1_y),
        .c_o      (tq0_y)
    );

    spc_third u_third_p1x (
        .aclk     (aclk),
        .adv      (adv),
        .from_i   (st1_reg.d_x),
        .toward_i (st1_reg.p1_x),
        .c_o      (tq1_x)
    );

    spc_third u_third_p1y (
        .aclk     (aclk),
        .adv      (adv),
        .from_i   (st1_reg.d_y),
        .toward_i (st1_reg.p1_y),
        .c_o      (tq1_y)
    );

    // ---------------------------------------------------------------
    // output beat register
    // ---------------------------------------------------------------
    logic [1:0]  kind_reg,  kind_next;
    logic [31:0] pt0x_reg,  pt0x_next;
    logic [31:0] pt0y_reg,  pt0y_next;
    logic [31:0] pt1x_reg,  pt1x_next;
    logic [31:0] pt1y_reg,  pt1y_next;
    logic [31:0] dstx_reg,  dstx_next;
    logic [31:0] dsty_reg,  dsty_next;
    logic        last_reg,  last_next;

    logic        is_cubic5;
    logic [31:0] raw_p0x;

    assign is_cubic5 = (st5_reg.kind == spc_pkg::KIND_CUBIC);
    assign raw_p0x   = st5_reg.is_quad ? tq0_x : st5_reg.p0_x;

    // whole-number x of a cubic gets the configured fraction
    function automatic logic [31:0] nudge(input logic [31:0] x, input logic en,
                                          input logic [15:0] amt);
        logic [31:0] r;
        r = x;
        if (en && (x[15:0] == 16'd0)) begin
            r = x + {16'd0, amt};
        end
        return r;
    endfunction

    always_comb begin
        if (pend_reg) begin
            kind_next = spc_pkg::KIND_MOVE;
            pt0x_next = '0;
            pt0y_next = '0;
            pt1x_next = '0;
            pt1y_next = '0;
            dstx_next = st5_reg.mv_x;
            dsty_next = st5_reg.mv_y;
            last_next = 1'b0;
        end else begin
            kind_next = st5_reg.kind;
            pt0x_next = nudge(raw_p0x, nudge_en_reg && is_cubic5, nudge_amt_reg);
            pt0y_next = st5_reg.is_quad ? tq0_y : st5_reg.p0_y;
            pt1x_next = st5_reg.is_quad ? tq1_x : st5_reg.p1_x;
            pt1y_next = st5_reg.is_quad ? tq1_y : st5_reg.p1_y;
            dstx_next = nudge(st5_reg.d_x, nudge_en_reg && is_cubic5, nudge_amt_reg);
            dsty_next = st5_reg.d_y;
            last_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_ld) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ld) begin
            kind_reg <= kind_next;
            pt0x_reg <= pt0x_next;
            pt0y_reg <= pt0y_next;
            pt1x_reg <= pt1x_next;
            pt1y_reg <= pt1y_next;
            dstx_reg <= dstx_next;
            dsty_reg <= dsty_next;
            last_reg <= last_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {dsty_reg, dstx_reg, pt1y_reg, pt1x_reg, pt0y_reg, pt0x_reg};

endmodule

`default_nettype wire

/* tb/sv/tb_svg_path_to_cubic_segments_top.sv */
`timescale 1ns / 1ps

module tb_svg_path_to_cubic_segments_top;

    // request codes outside the command set
    localparam logic [3:0] REQ_UNKNOWN_LO = 4'd9;
    localparam logic [3:0] REQ_UNKNOWN_HI = 4'd15;

    // one path command
    typedef struct packed {
        logic [3:0]  req_type;
        logic        relative;
        logic [31:0] ctrl1_x;
        logic [31:0] ctrl1_y;
        logic [31:0] ctrl2_x;
        logic [31:0] ctrl2_y;
        logic [31:0] end_x;
        logic [31:0] end_y;
    } path_cmd_t;

    // one expected output segment
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] p0_x;
        logic [31:0] p0_y;
        logic [31:0] p1_x;
        logic [31:0] p1_y;
        logic [31:0] d_x;
        logic [31:0] d_y;
        logic        last;
    } segment_t;

    // dut ports, inputs known from time zero
    logic         aclk;
    logic         aresetn   = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    // ctrl1_x[31:0], ctrl1_y[63:32], ctrl2_x[95:64], ctrl2_y[127:96],
    // end_x[159:128], end_y[191:160]
    logic [191:0] s_tdata   = '0;
    // req_type[3:0], relative[4]
    logic [4:0]   s_tuser   = '0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    // pt0_x[31:0], pt0_y[63:32], pt1_x[95:64], pt1_y[127:96],
    // dest_x[159:128], dest_y[191:160]
    logic [191:0] m_tdata;
    // seg_kind[1:0]
    logic [1:0]   m_tuser;
    logic         m_tlast;
    logic         cfg_we    = 1'b0;
    logic [0:0]   cfg_index = '0;
    logic [15:0]  cfg_wdata = '0;

    svg_path_to_cubic_segments_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // path tracker state, mirrors what the block keeps between commands
    logic [31:0] pen_x, pen_y;          // current point
    logic [31:0] start_x, start_y;      // subpath start
    logic [31:0] ctl_x, ctl_y;          // last control point
    bit          after_cubic, after_quad;
    bit          moveto_owed;           // next drawing command opens a subpath
    bit          nudge_on;
    logic [15:0] nudge_amt;

    segment_t    pending_segs[$];       // segments still owed by the block

    int          error_count   = 0;
    int          cmds_sent     = 0;     // accepted commands with a known code
    int          ignored_sent  = 0;     // accepted commands with an unknown code
    int          segs_checked  = 0;
    int          kind_seen[4]  = '{0, 0, 0, 0};
    int          settings_run  = 0;

    // sender burst shaping
    int          burst_left    = 0;
    int          gap_max       = 4;

    // receiver hold-off request, consumed by the receiver process
    bit          hold_req      = 1'b0;
    int          hold_len      = 0;

    // 10 ns clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // control point 2/3 of the way from an end point toward q, rounded to nearest
    function automatic logic [31:0] two_thirds_toward(logic [31:0] from, logic [31:0] toward);
        logic [31:0] diff;
        longint      num;
        longint      quo;
        diff = toward - from;
        num  = 2 * longint'($signed(diff)) + 1;
        quo  = num / 3;
        if (num % 3 < 0)
            quo = quo - 1;
        return from + quo[31:0];
    endfunction

    // whole-number x gets the configured fraction added
    function automatic logic [31:0] nudged(logic [31:0] x);
        if (nudge_on && x[15:0] == 16'h0000)
            return x + {16'h0000, nudge_amt};
        return x;
    endfunction

    function automatic void owe_segment(logic [1:0] kind, logic [31:0] ax, logic [31:0] ay,
                                        logic [31:0] bx, logic [31:0] by,
                                        logic [31:0] dx, logic [31:0] dy, logic last);
        segment_t s;
        s = '{kind, ax, ay, bx, by, dx, dy, last};
        pending_segs.push_back(s);
    endfunction

    function automatic void reset_path_state();
        pen_x = '0;   pen_y = '0;
        start_x = '0; start_y = '0;
        ctl_x = '0;   ctl_y = '0;
        after_cubic = 1'b0;
        after_quad  = 1'b0;
        moveto_owed = 1'b1;
        nudge_on    = 1'b1;
        nudge_amt   = 16'd655;
    endfunction

    // works out the segments one accepted command causes and updates the path state
    function automatic void trace_command(path_cmd_t c);
        logic [31:0] ox, oy, a1x, a1y, a2x, a2y, tx, ty, qx, qy;
        if (c.req_type > spc_pkg::REQ_CLOSE)
            return;
        ox  = c.relative ? pen_x : 32'h0;
        oy  = c.relative ? pen_y : 32'h0;
        a1x = c.ctrl1_x + ox;
        a1y = c.ctrl1_y + oy;
        a2x = c.ctrl2_x + ox;
        a2y = c.ctrl2_y + oy;
        tx  = c.end_x + ox;
        ty  = c.end_y + oy;
        if (moveto_owed && c.req_type != spc_pkg::REQ_MOVE)
            owe_segment(spc_pkg::KIND_MOVE, '0, '0, '0, '0, start_x, start_y, 1'b0);
        moveto_owed = 1'b0;
        case (c.req_type)
            spc_pkg::REQ_MOVE: begin
                pen_x = tx;   pen_y = ty;
                start_x = tx; start_y = ty;
                owe_segment(spc_pkg::KIND_MOVE, '0, '0, '0, '0, tx, ty, 1'b1);
                after_cubic = 1'b0;
                after_quad  = 1'b0;
            end
            spc_pkg::REQ_LINE, spc_pkg::REQ_HLINE, spc_pkg::REQ_VLINE: begin
                if (c.req_type != spc_pkg::REQ_VLINE)
                    pen_x = tx;
                if (c.req_type != spc_pkg::REQ_HLINE)
                    pen_y = ty;
                owe_segment(spc_pkg::KIND_LINE, '0, '0, '0, '0, pen_x, pen_y, 1'b1);
                after_cubic = 1'b0;
                after_quad  = 1'b0;
            end
            spc_pkg::REQ_CUBIC, spc_pkg::REQ_SCUBIC: begin
                if (c.req_type == spc_pkg::REQ_CUBIC) begin
                    qx = a1x; qy = a1y;
                end else if (after_cubic) begin
                    qx = (pen_x << 1) - ctl_x;
                    qy = (pen_y << 1) - ctl_y;
                end else begin
                    qx = pen_x; qy = pen_y;
                end
                owe_segment(spc_pkg::KIND_CUBIC, nudged(qx), qy, a2x, a2y,
                            nudged(tx), ty, 1'b1);
                pen_x = tx;  pen_y = ty;
                ctl_x = a2x; ctl_y = a2y;
                after_cubic = 1'b1;
                after_quad  = 1'b0;
            end
            spc_pkg::REQ_QUAD, spc_pkg::REQ_SQUAD: begin
                if (c.req_type == spc_pkg::REQ_QUAD) begin
                    qx = a2x; qy = a2y;
                end else if (after_quad) begin
                    qx = (pen_x << 1) - ctl_x;
                    qy = (pen_y << 1) - ctl_y;
                end else begin
                    qx = pen_x; qy = pen_y;
                end
                owe_segment(spc_pkg::KIND_CUBIC, nudged(two_thirds_toward(pen_x, qx)),
                            two_thirds_toward(pen_y, qy),
                            two_thirds_toward(tx, qx), two_thirds_toward(ty, qy),
                            nudged(tx), ty, 1'b1);
                pen_x = tx; pen_y = ty;
                ctl_x = qx; ctl_y = qy;
                after_cubic = 1'b0;
                after_quad  = 1'b1;
            end
            default: begin
                owe_segment(spc_pkg::KIND_CLOSE, '0, '0, '0, '0, start_x, start_y, 1'b1);
                pen_x = start_x;
                pen_y = start_y;
                after_cubic = 1'b0;
                after_quad  = 1'b0;
                moveto_owed = 1'b1;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic path_cmd_t make_cmd(logic [3:0] t, logic rel,
                                           logic [31:0] c1x, logic [31:0] c1y,
                                           logic [31:0] c2x, logic [31:0] c2y,
                                           logic [31:0] ex, logic [31:0] ey);
        path_cmd_t c;
        c = '{t, rel, c1x, c1y, c2x, c2y, ex, ey};
        return c;
    endfunction

    // coordinate mix: full range, whole numbers (nudge hits), small values, extremes
    function automatic logic [31:0] rand_coord();
        logic [31:0] t, r;
        t = $urandom;
        case ($urandom_range(0, 6))
            0, 1:    r = t;
            2:       r = {t[31:16], 16'h0000};
            3:       r = {{12{t[3]}}, t[3:0], 16'h0000};
            4:       r = {{16{t[31]}}, t[15:0]};
            5: begin
                case (t[1:0])
                    2'd0:    r = 32'h7FFF_FFFF;
                    2'd1:    r = 32'h8000_0000;
                    2'd2:    r = 32'h0000_0000;
                    default: r = 32'hFFFF_FFFF;
                endcase
            end
            default: r = {{12{t[19]}}, t[19:0]};
        endcase
        return r;
    endfunction

    function automatic path_cmd_t rand_cmd(logic [3:0] t);
        return make_cmd(t, 1'($urandom_range(0, 1)), rand_coord(), rand_coord(),
                        rand_coord(), rand_coord(), rand_coord(), rand_coord());
    endfunction

    // offers one command, waits for its accept beat, then records what it owes
    task automatic send_cmd(path_cmd_t c);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tdata  <= {c.end_y, c.end_x, c.ctrl2_y, c.ctrl2_x, c.ctrl1_y, c.ctrl1_x};
        s_tuser  <= {c.relative, c.req_type};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        trace_command(c);
        if (c.req_type > spc_pkg::REQ_CLOSE)
            ignored_sent++;
        else
            cmds_sent++;
    endtask

    // stop offering and let every owed segment come out, then cover the pipe latency
    task automatic wait_idle();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_segs.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [15:0] val);
        cfg_index <= idx;
        cfg_wdata <= val;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
        if (idx == spc_pkg::CFG_NUDGE_EN)
            nudge_on = val[0];
        else
            nudge_amt = val;
    endtask

    // well-formed subpaths with random content, plus some noise commands
    task automatic send_subpaths(int count);
        int goal;
        int k;
        goal = cmds_sent + count;
        while (cmds_sent < goal) begin
            if ($urandom_range(0, 99) < 12) begin
                send_cmd(rand_cmd(4'($urandom_range(0, 15))));
            end else begin
                if ($urandom_range(0, 3) != 0)
                    send_cmd(rand_cmd(spc_pkg::REQ_MOVE));
                k = $urandom_range(1, 8);
                repeat (k)
                    send_cmd(rand_cmd(4'($urandom_range(spc_pkg::REQ_LINE,
                                                        spc_pkg::REQ_SQUAD))));
                if ($urandom_range(0, 9) < 7)
                    send_cmd(rand_cmd(spc_pkg::REQ_CLOSE));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // hand-picked commands at reset settings: every code, both coordinate modes,
    // wrap at the field limits, reflections with and without a matching curve,
    // double close, drawing right after close, unknown codes
    task automatic test_directed();
        gap_max = 4;
        // first drawing command opens the subpath at the origin
        send_cmd(make_cmd(spc_pkg::REQ_HLINE, 1'b0, '0, '0, '0, '0, 32'h0003_0000, '0));
        send_cmd(make_cmd(spc_pkg::REQ_VLINE, 1'b1, '0, '0, '0, '0, '0, 32'h7FFF_FFFF));
        // relative line that wraps both coordinates
        send_cmd(make_cmd(spc_pkg::REQ_LINE, 1'b1, '0, '0, '0, '0,
                          32'h7FFF_FFFF, 32'h0000_0001));
        send_cmd(make_cmd(spc_pkg::REQ_MOVE, 1'b0, '0, '0, '0, '0,
                          32'h8000_0000, 32'h7FFF_FFFF));
        // whole-number x on control and end, nudge applies to both
        send_cmd(make_cmd(spc_pkg::REQ_CUBIC, 1'b0, 32'h0001_0000, 32'h8000_0000,
                          32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0005_0000, 32'h0000_0000));
        // smooth cubic after a cubic reflects the old second control
        send_cmd(make_cmd(spc_pkg::REQ_SCUBIC, 1'b0, '0, '0, 32'h0003_8000, 32'h0001_0000,
                          32'h0002_0000, 32'h0002_0000));
        send_cmd(make_cmd(spc_pkg::REQ_LINE, 1'b0, '0, '0, '0, '0, '0, '0));
        // smooth cubic after a line: first control sits on the current point
        send_cmd(make_cmd(spc_pkg::REQ_SCUBIC, 1'b1, '0, '0, 32'h0001_2345, 32'hFFFF_0000,
                          32'h0004_0000, 32'h0000_8000));
        send_cmd(make_cmd(spc_pkg::REQ_QUAD, 1'b0, '0, '0, 32'h0004_0000, 32'h0004_0000,
                          32'h0008_0000, 32'h0000_0000));
        // smooth quadratic after a quadratic reflects the quad control
        send_cmd(make_cmd(spc_pkg::REQ_SQUAD, 1'b1, '0, '0, '0, '0,
                          32'h0001_0000, 32'h0001_0000));
        send_cmd(make_cmd(spc_pkg::REQ_CUBIC, 1'b1, 32'h8000_0000, 32'h8000_0000,
                          32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
        // smooth quadratic after a cubic gets no reflection
        send_cmd(make_cmd(spc_pkg::REQ_SQUAD, 1'b0, '0, '0, '0, '0,
                          32'h0000_0003, 32'hFFFF_FFFD));
        send_cmd(make_cmd(spc_pkg::REQ_QUAD, 1'b1, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'h8000_0001, 32'h7FFF_FFFE));
        send_cmd(make_cmd(spc_pkg::REQ_CLOSE, 1'b0, '0, '0, '0, '0, '0, '0));
        // close with the subpath already closed: leading moveto first
        send_cmd(make_cmd(spc_pkg::REQ_CLOSE, 1'b1, '1, '1, '1, '1, '1, '1));
        // drawing right after close reopens at the subpath start
        send_cmd(make_cmd(spc_pkg::REQ_LINE, 1'b0, '0, '0, '0, '0,
                          32'h0010_0000, 32'hFFF0_0000));
        send_cmd(make_cmd(spc_pkg::REQ_CLOSE, 1'b0, '0, '0, '0, '0, '0, '0));
        // move after close emits only its own moveto
        send_cmd(make_cmd(spc_pkg::REQ_MOVE, 1'b1, '1, '1, '1, '1,
                          32'hFFFF_8000, 32'h0000_8000));
        // unknown codes leave everything alone
        send_cmd(make_cmd(REQ_UNKNOWN_LO, 1'b1, '1, '1, '1, '1, '1, '1));
        send_cmd(make_cmd(REQ_UNKNOWN_HI, 1'b0, '1, '1, '1, '1, '1, '1));
        send_cmd(make_cmd(spc_pkg::REQ_CUBIC, 1'b1, '1, '1, '1, '1, '1, '1));
        // smooth cubic after a quadratic gets no reflection
        send_cmd(make_cmd(spc_pkg::REQ_QUAD, 1'b0, '0, '0, 32'h0002_0000, 32'h0006_0000,
                          32'h0007_0000, 32'h0001_0000));
        send_cmd(make_cmd(spc_pkg::REQ_SCUBIC, 1'b0, '0, '0, 32'h0000_0000, 32'h0000_0000,
                          32'h0001_0000, 32'h0002_0000));
        send_cmd(make_cmd(spc_pkg::REQ_CLOSE, 1'b0, '0, '0, '0, '0, '0, '0));
        wait_idle();
    endtask

    // receiver holds off long enough that the pipe fills and s_tready drops
    task automatic test_output_holdoff();
        gap_max  = 0;
        hold_len = 400;
        hold_req = 1'b1;
        send_subpaths(80);
        wait_idle();
    endtask

    // nudge registers swept through their extremes, each setting with fresh traffic
    task automatic test_nudge_settings();
        bit          en_list[5]  = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
        logic [15:0] amt_list[5];
        amt_list = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000};
        amt_list[4] = 16'($urandom_range(1, 65534));
        for (int i = 0; i < 5; i++) begin
            gap_max = (i % 2 == 0) ? 8 : 2;
            wait_idle();
            write_reg(spc_pkg::CFG_NUDGE_EN, {15'h0000, en_list[i]});
            write_reg(spc_pkg::CFG_NUDGE_AMT, amt_list[i]);
            settings_run++;
            send_subpaths(120);
        end
        wait_idle();
    endtask

    // bulk random traffic in chunks with varying sender gaps; some chunks end in a
    // full pause until the block has drained
    task automatic test_random_paths();
        int gap_pick[3] = '{0, 3, 12};
        for (int i = 0; i < 7; i++) begin
            gap_max = gap_pick[$urandom_range(0, 2)];
            send_subpaths(130);
            if ($urandom_range(0, 2) == 0)
                wait_idle();
        end
        gap_max = 0;
        send_subpaths(100);
    endtask

    // ------------------------------------------------------------------
    // receiver: stall pattern of its own, plus counted hold-offs on request
    // ------------------------------------------------------------------
    int rx_mode      = 0;
    int rx_mode_left = 0;
    int rx_hold_left = 0;
    int rx_phase     = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_req || rx_hold_left > 0) begin
            if (hold_req) begin
                rx_hold_left = hold_len;
                hold_req     = 1'b0;
            end
            rx_hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(20, 200);
            end else begin
                rx_mode_left--;
            end
            rx_phase++;
            case (rx_mode)
                0:       m_tready <= 1'b1;                           // never stalls
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= (rx_phase % 5 != 0);            // periodic stall
            endcase
        end
    end

    // ------------------------------------------------------------------
    // checker: every segment beat against the oldest owed segment
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            error_count++;
        end
    endfunction

    segment_t want_seg;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_segs.size() == 0) begin
                $error("segment beat with none owed: tuser %h tdata %h tlast %b",
                       m_tuser, m_tdata, m_tlast);
                error_count++;
            end else begin
                want_seg = pending_segs.pop_front();
                check_field("seg_kind", 32'(want_seg.kind), 32'(m_tuser));
                check_field("pt0_x",    want_seg.p0_x, m_tdata[31:0]);
                check_field("pt0_y",    want_seg.p0_y, m_tdata[63:32]);
                check_field("pt1_x",    want_seg.p1_x, m_tdata[95:64]);
                check_field("pt1_y",    want_seg.p1_y, m_tdata[127:96]);
                check_field("dest_x",   want_seg.d_x,  m_tdata[159:128]);
                check_field("dest_y",   want_seg.d_y,  m_tdata[191:160]);
                check_field("last",     32'(want_seg.last), 32'(m_tlast));
                segs_checked++;
                kind_seen[want_seg.kind]++;
            end
        end
    end

    // ------------------------------------------------------------------
    // run sequence
    // ------------------------------------------------------------------
    initial begin
        reset_path_state();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_output_holdoff();
        test_nudge_settings();
        test_random_paths();

        wait_idle();
        if (pending_segs.size() != 0) begin
            $error("%0d owed segments never arrived", pending_segs.size());
            error_count++;
        end

        $display("run covered %0d path commands (+%0d unknown codes), %0d segments checked",
                 cmds_sent, ignored_sent, segs_checked);
        $display("kinds moveto %0d lineto %0d cubic %0d close %0d, %0d nudge settings swept",
                 kind_seen[spc_pkg::KIND_MOVE], kind_seen[spc_pkg::KIND_LINE],
                 kind_seen[spc_pkg::KIND_CUBIC], kind_seen[spc_pkg::KIND_CLOSE],
                 settings_run);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // hard stop well past the slowest correct run
    initial begin
        #5_000_000;
        $display("timeout waiting for the block");
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* filelist.f */
hdl/spc_pkg.sv
hdl/spc_third.sv
hdl/svg_path_to_cubic_segments_top.sv
tb/sv/tb_svg_path_to_cubic_segments_top.sv
